>>> hdl/htl_pkg.sv
// shared types, constants and helpers of the html token lexer
// no dependencies; imported by every module of the block
`default_nettype none

package htl_pkg;

   // width of the internal byte counters (saturating)
   localparam int POS_W = 32;
   // width of the reported offset and length fields
   localparam int OUT_W = 32;
   localparam int EXT_W = (POS_W + 1 > OUT_W + 1) ? POS_W + 1 : OUT_W + 1;

   // result queue between the scanner and the output side
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [2:0] KIND_TEXT    = 3'd0;
   localparam logic [2:0] KIND_COMMENT = 3'd1;
   localparam logic [2:0] KIND_DECL    = 3'd2;
   localparam logic [2:0] KIND_START   = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   // characters of interest
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [2:0]       token_kind;
      logic [OUT_W-1:0] token_start;
      logic [OUT_W-1:0] token_length;
      logic             terminated;
      logic             last_of_run;
   } rsp_type;

   // all results caused by one request byte
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } entry_type;

   function automatic logic [OUT_W-1:0] clamp_out(input logic [POS_W:0] v);
      logic [EXT_W-1:0] x;
      x = EXT_W'(v);
      if (x > EXT_W'({OUT_W{1'b1}}))
         clamp_out = '1;
      else
         clamp_out = x[OUT_W-1:0];
   endfunction

   function automatic logic is_white(input logic [7:0] b);
      is_white = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

endpackage

`default_nettype wire

>>> hdl/htl_front.sv
// scanner: accepts request bytes, tracks the token state and builds result entries
// depends on htl_pkg
`default_nettype none

module htl_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire htl_pkg::req_type   req_data,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output htl_pkg::entry_type      push_data
);
   import htl_pkg::*;

   localparam logic [3:0] M_IDLE         = 4'd0;
   localparam logic [3:0] M_TEXT         = 4'd1;
   localparam logic [3:0] M_LT           = 4'd2;
   localparam logic [3:0] M_LT_BANG      = 4'd3;
   localparam logic [3:0] M_LT_BANG_DASH = 4'd4;
   localparam logic [3:0] M_C_BODY       = 4'd5;
   localparam logic [3:0] M_C_DASH       = 4'd6;
   localparam logic [3:0] M_C_SPACE      = 4'd7;
   localparam logic [3:0] M_TAG          = 4'd8;
   localparam logic [3:0] M_QUOTED       = 4'd9;

   logic [3:0]       mode_ff, mode_in;
   logic             quote_ff, quote_in;
   logic [2:0]       pend_ff, pend_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] begin_ff, begin_in;

   logic [7:0]       b;
   logic             accept;
   logic [3:0]       mode_mid;
   logic             quote_mid;
   logic [2:0]       pend_mid;
   logic [POS_W-1:0] begin_mid;
   logic             scan_quote, scan_close;
   logic [3:0]       scan_mode;
   logic             step_put, flush;
   logic [2:0]       step_kind, flush_kind;
   logic [POS_W:0]   step_len, flush_len, through_len, text_len;
   rsp_type          step_rsp, flush_rsp;

   assign b         = req_data.data_byte;
   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   // quote-aware tag and declaration scan
   always_comb begin
      scan_quote = quote_ff;
      scan_close = 1'b0;
      scan_mode  = M_TAG;
      if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         scan_quote = (b == CH_SQUOTE);
         scan_mode  = M_QUOTED;
      end else if (b == CH_GT) begin
         scan_close = 1'b1;
         scan_mode  = M_IDLE;
      end
   end

   assign through_len = (POS_W + 1)'({1'b0, pos_ff} - {1'b0, begin_ff} + 1'b1);
   assign text_len    = ((pos_ff - begin_ff) == '0) ? (POS_W + 1)'(1)
                                                    : {1'b0, pos_ff - begin_ff};
   assign flush_len   = (POS_W + 1)'({1'b0, pos_ff} - {1'b0, begin_mid} + 1'b1);

   always_comb begin
      mode_mid  = mode_ff;
      quote_mid = quote_ff;
      pend_mid  = pend_ff;
      begin_mid = begin_ff;
      step_put  = 1'b0;
      step_kind = KIND_TEXT;
      step_len  = through_len;
      case (mode_ff)
         M_IDLE: begin
            begin_mid = pos_ff;
            mode_mid  = (b == CH_LT) ? M_LT : M_TEXT;
         end
         M_TEXT: begin
            if (b == CH_LT) begin
               step_put  = 1'b1;
               step_kind = KIND_TEXT;
               step_len  = text_len;
               begin_mid = pos_ff;
               mode_mid  = M_LT;
            end
         end
         M_LT: begin
            if (b == CH_BANG) begin
               mode_mid = M_LT_BANG;
            end else begin
               pend_mid  = (b == CH_SLASH) ? KIND_END : KIND_START;
               mode_mid  = scan_mode;
               quote_mid = scan_quote;
               step_put  = scan_close;
               step_kind = pend_mid;
            end
         end
         M_LT_BANG, M_LT_BANG_DASH: begin
            if (b == CH_DASH && mode_ff == M_LT_BANG) begin
               mode_mid = M_LT_BANG_DASH;
            end else if (b == CH_DASH) begin
               pend_mid = KIND_COMMENT;
               mode_mid = M_C_BODY;
            end else begin
               pend_mid  = KIND_DECL;
               mode_mid  = scan_mode;
               quote_mid = scan_quote;
               step_put  = scan_close;
               step_kind = KIND_DECL;
            end
         end
         M_C_BODY: begin
            if (b == CH_DASH)
               mode_mid = M_C_DASH;
         end
         M_C_DASH, M_C_SPACE: begin
            if (b == CH_DASH && mode_ff == M_C_DASH) begin
               mode_mid = M_C_DASH;
            end else if (is_white(b)) begin
               mode_mid = M_C_SPACE;
            end else if (b == CH_GT) begin
               step_put  = 1'b1;
               step_kind = KIND_COMMENT;
               mode_mid  = M_IDLE;
            end else begin
               mode_mid = M_C_BODY;
            end
         end
         M_TAG: begin
            mode_mid  = scan_mode;
            quote_mid = scan_quote;
            step_put  = scan_close;
            step_kind = pend_ff;
         end
         M_QUOTED: begin
            if (b == (quote_ff ? CH_SQUOTE : CH_DQUOTE))
               mode_mid = M_TAG;
         end
         default: begin
            mode_mid = M_IDLE;
         end
      endcase
   end

   // end-of-file flush of whatever token is still open
   always_comb begin
      flush = req_data.end_of_file && (mode_mid != M_IDLE);
      case (mode_mid)
         M_TEXT:                               flush_kind = KIND_TEXT;
         M_LT:                                 flush_kind = KIND_START;
         M_LT_BANG, M_LT_BANG_DASH:            flush_kind = KIND_DECL;
         M_C_BODY, M_C_DASH, M_C_SPACE:        flush_kind = KIND_COMMENT;
         default:                              flush_kind = pend_mid;
      endcase
   end

   always_comb begin
      step_rsp.token_kind    = step_kind;
      step_rsp.token_start   = clamp_out({1'b0, begin_ff});
      step_rsp.token_length  = clamp_out(step_len);
      step_rsp.terminated    = 1'b1;
      step_rsp.last_of_run   = !flush;
      flush_rsp.token_kind   = flush_kind;
      flush_rsp.token_start  = clamp_out({1'b0, begin_mid});
      flush_rsp.token_length = clamp_out(flush_len);
      flush_rsp.terminated   = 1'b0;
      flush_rsp.last_of_run  = 1'b1;
      push_data.two          = step_put && flush;
      push_data.first        = step_put ? step_rsp : flush_rsp;
      push_data.second       = flush_rsp;
   end

   assign push_valid = req_valid && (step_put || flush);

   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      pend_in  = pend_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      if (accept) begin
         if (req_data.end_of_file) begin
            mode_in  = M_IDLE;
            quote_in = 1'b0;
            pend_in  = KIND_TEXT;
            pos_in   = '0;
            begin_in = '0;
         end else begin
            mode_in  = mode_mid;
            quote_in = quote_mid;
            pend_in  = pend_mid;
            begin_in = begin_mid;
            if (pos_ff != '1)
               pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         quote_ff <= 1'b0;
         pend_ff  <= KIND_TEXT;
         pos_ff   <= '0;
         begin_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/htl_queue.sv
// short first-in first-out queue of result entries
// depends on htl_pkg
`default_nettype none

module htl_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire htl_pkg::entry_type  push_data,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output htl_pkg::entry_type       pop_data
);
   import htl_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign push_ready = (cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? QUEUE_IDX_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? QUEUE_IDX_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)
         cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

>>> hdl/htl_back.sv
// output side: hands out the one or two results of each queued entry
// depends on htl_pkg
`default_nettype none

module htl_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire htl_pkg::entry_type  pop_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output htl_pkg::rsp_type         rsp_data
);
   import htl_pkg::*;

   // set while the second result of a two-result entry is on offer
   logic sub_ff, sub_in;

   assign rsp_valid = pop_valid;
   assign rsp_data  = sub_ff ? pop_data.second : pop_data.first;
   assign pop_ready = rsp_ready && (!pop_data.two || sub_ff);

   always_comb begin
      sub_in = sub_ff;
      if (rsp_valid && rsp_ready)
         sub_in = pop_data.two && !sub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/html_token_lexer_top.sv
// top level of the html token lexer: scanner, result queue and output side
// depends on htl_pkg, htl_front, htl_queue, htl_back
`default_nettype none

// The lexer takes one document byte per request and reports a descriptor
// (kind, start offset, length, terminated flag) for each finished token:
// text runs, comments, declarations, start tags and end tags. It accepts
// one request per clock; every byte is classified by the scanner state
// machine. A byte yields zero, one or two results; results wait in a
// four-entry queue, and the output side hands out one result at a time,
// so a byte giving two results (text closed by '<' on the end-of-file
// byte) takes two output transfers. Requests stall only while the queue
// is full. The end-of-file byte flushes any open token with terminated
// low and returns the scanner to its reset state. Offsets and lengths
// saturate; last_of_run marks the final result caused by a request.
module html_token_lexer_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire htl_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output htl_pkg::rsp_type       rsp_data
);
   import htl_pkg::*;

   // scanner to queue
   logic      push_valid, push_ready;
   entry_type push_data;
   // queue to output side
   logic      pop_valid, pop_ready;
   entry_type pop_data;

   // token state machine and result building
   htl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples the scanner from output back-pressure
   htl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // serialises one or two results per entry
   htl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> dv/html_token_lexer_checker.sv
`timescale 1ns / 100ps
// checker of the html token lexer: watches both channels, predicts the token
// descriptors of every accepted byte request and compares them in order
// depends on htl_pkg
module html_token_lexer_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire htl_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire htl_pkg::rsp_type rsp_data,
   output int                    error_count,
   output int                    pending_count
);
   import htl_pkg::*;

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_TEXT,
      SCAN_LT,
      SCAN_LT_BANG,
      SCAN_LT_BANG_DASH,
      SCAN_COMMENT,
      SCAN_COMMENT_DASH,
      SCAN_COMMENT_SPACE,
      SCAN_TAG,
      SCAN_QUOTED
   } scan_mode_type;

   localparam logic [63:0] POS_LIMIT =
      (POS_W >= 64) ? {64{1'b1}} : ((64'd1 << POS_W) - 64'd1);
   localparam logic [63:0] OUT_LIMIT =
      (OUT_W >= 64) ? {64{1'b1}} : ((64'd1 << OUT_W) - 64'd1);

   scan_mode_type scan_mode;
   logic          quote_single;
   logic [2:0]    tag_kind;
   logic [63:0]   byte_pos;
   logic [63:0]   token_from;

   rsp_type expected_tokens[$];
   rsp_type step_tokens[2];
   int      step_count;
   rsp_type want;
   int      misses;

   function automatic logic white_byte(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic logic [OUT_W-1:0] clip(input logic [63:0] v);
      return (v > OUT_LIMIT) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
   endfunction

   // bytes from the token's first byte through the current one
   function automatic logic [63:0] span_to_here();
      if (token_from > byte_pos)
         return 64'd1;
      if (byte_pos - token_from == {64{1'b1}})
         return {64{1'b1}};
      return byte_pos - token_from + 64'd1;
   endfunction

   function automatic int check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0d actual %0d", name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   task automatic clear_scanner();
      scan_mode = SCAN_IDLE;
      quote_single = 1'b0;
      tag_kind = KIND_TEXT;
      byte_pos = '0;
      token_from = '0;
   endtask

   task automatic add_token(input logic [2:0] kind, input logic [63:0] len,
                            input logic closed);
      rsp_type t;
      t.token_kind = kind;
      t.token_start = clip(token_from);
      t.token_length = clip((len == 64'd0) ? 64'd1 : len);
      t.terminated = closed;
      t.last_of_run = 1'b0;
      if (step_count < 2) begin
         step_tokens[step_count] = t;
         step_count++;
      end
   endtask

   // tag and declaration body: quotes hide a closing bracket
   task automatic scan_tag(input logic [7:0] b);
      if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         quote_single = (b == CH_SQUOTE);
         scan_mode = SCAN_QUOTED;
      end else if (b == CH_GT) begin
         add_token(tag_kind, span_to_here(), 1'b1);
         scan_mode = SCAN_IDLE;
      end else begin
         scan_mode = SCAN_TAG;
      end
   endtask

   task automatic predict_tokens(input req_type r);
      logic [7:0] b;
      logic [2:0] cut_kind;
      b = r.data_byte;
      step_count = 0;
      case (scan_mode)
         SCAN_IDLE: begin
            token_from = byte_pos;
            scan_mode = (b == CH_LT) ? SCAN_LT : SCAN_TEXT;
         end
         SCAN_TEXT: begin
            if (b == CH_LT) begin
               add_token(KIND_TEXT, byte_pos - token_from, 1'b1);
               token_from = byte_pos;
               scan_mode = SCAN_LT;
            end
         end
         SCAN_LT: begin
            if (b == CH_BANG) begin
               scan_mode = SCAN_LT_BANG;
            end else begin
               tag_kind = (b == CH_SLASH) ? KIND_END : KIND_START;
               scan_tag(b);
            end
         end
         SCAN_LT_BANG: begin
            if (b == CH_DASH) begin
               scan_mode = SCAN_LT_BANG_DASH;
            end else begin
               tag_kind = KIND_DECL;
               scan_tag(b);
            end
         end
         SCAN_LT_BANG_DASH: begin
            if (b == CH_DASH) begin
               tag_kind = KIND_COMMENT;
               scan_mode = SCAN_COMMENT;
            end else begin
               tag_kind = KIND_DECL;
               scan_tag(b);
            end
         end
         SCAN_COMMENT: begin
            if (b == CH_DASH)
               scan_mode = SCAN_COMMENT_DASH;
         end
         SCAN_COMMENT_DASH, SCAN_COMMENT_SPACE: begin
            if (b == CH_DASH && scan_mode == SCAN_COMMENT_DASH) begin
               scan_mode = SCAN_COMMENT_DASH;
            end else if (white_byte(b)) begin
               scan_mode = SCAN_COMMENT_SPACE;
            end else if (b == CH_GT) begin
               add_token(KIND_COMMENT, span_to_here(), 1'b1);
               scan_mode = SCAN_IDLE;
            end else begin
               scan_mode = SCAN_COMMENT;
            end
         end
         SCAN_TAG: scan_tag(b);
         SCAN_QUOTED: begin
            if (b == (quote_single ? CH_SQUOTE : CH_DQUOTE))
               scan_mode = SCAN_TAG;
         end
         default: scan_mode = SCAN_IDLE;
      endcase

      if (r.end_of_file) begin
         if (scan_mode != SCAN_IDLE) begin
            case (scan_mode)
               SCAN_TEXT:                          cut_kind = KIND_TEXT;
               SCAN_LT:                            cut_kind = KIND_START;
               SCAN_LT_BANG, SCAN_LT_BANG_DASH:    cut_kind = KIND_DECL;
               SCAN_COMMENT, SCAN_COMMENT_DASH,
               SCAN_COMMENT_SPACE:                 cut_kind = KIND_COMMENT;
               default:                            cut_kind = tag_kind;
            endcase
            add_token(cut_kind, span_to_here(), 1'b0);
         end
         clear_scanner();
      end else if (byte_pos < POS_LIMIT) begin
         byte_pos = byte_pos + 64'd1;
      end

      if (step_count > 0)
         step_tokens[step_count-1].last_of_run = 1'b1;
      for (int i = 0; i < step_count; i++)
         expected_tokens.push_back(step_tokens[i]);
   endtask

   // prediction first: a result never belongs to a request taken at the same edge
   // later than the ones already queued, so the order cannot matter
   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         expected_tokens.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         misses = 0;
         if (req_valid && req_ready)
            predict_tokens(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token with no request behind it: kind %0d start %0d length %0d",
                      rsp_data.token_kind, rsp_data.token_start, rsp_data.token_length);
               misses = 1;
            end else begin
               want = expected_tokens.pop_front();
               misses += check_field("token_kind", 32'(want.token_kind),
                                     32'(rsp_data.token_kind));
               misses += check_field("token_start", want.token_start, rsp_data.token_start);
               misses += check_field("token_length", want.token_length,
                                     rsp_data.token_length);
               misses += check_field("terminated", 32'(want.terminated),
                                     32'(rsp_data.terminated));
               misses += check_field("last_of_run", 32'(want.last_of_run),
                                     32'(rsp_data.last_of_run));
            end
         end
         error_count <= error_count + misses;
         pending_count <= expected_tokens.size();
      end
   end

endmodule

>>> dv/html_token_lexer_top_test.sv
`timescale 1ns / 100ps
// testbench top of the html token lexer: clock, reset, byte request stimulus,
// result back-pressure and the verdict; depends on htl_pkg, html_token_lexer_top
// and html_token_lexer_checker
module html_token_lexer_top_test;
   import htl_pkg::*;

   localparam int RANDOM_BYTES = 1900;   // rough size of the random part
   localparam int QUIET_AFTER  = 1650;   // no idling on either side from here on
   localparam int HOLD_AT      = 300;    // requests taken before the long hold-off
   localparam int HOLD_CYCLES  = 150;    // long enough to fill the result queue
   localparam int DRAIN_CYCLES = 20;     // settle time once nothing is outstanding
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int requests_taken = 0;
   int cycle_count = 0;
   bit quiet_phase = 1'b0;
   bit hold_done = 1'b0;

   // bytes of the document being built, end of file goes on the last one
   logic [7:0] doc_bytes[$];

   always #5 clock = ~clock;

   html_token_lexer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   html_token_lexer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // accepted requests, used to time the long hold-off
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         requests_taken <= requests_taken + 1;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [7:0] space_byte();
      logic [7:0] v;
      v = 8'($urandom_range(9, 14));
      return (v == 8'd14) ? CH_SPACE : v;
   endfunction

   function automatic logic [7:0] letter_byte();
      return 8'($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   // bytes that matter to the scanner, with some filler mixed in
   function automatic logic [7:0] markup_byte();
      case ($urandom_range(0, 11))
         0:       return CH_LT;
         1:       return CH_GT;
         2, 3:    return CH_DASH;
         4:       return CH_BANG;
         5:       return CH_SLASH;
         6:       return CH_DQUOTE;
         7:       return CH_SQUOTE;
         8:       return space_byte();
         9:       return letter_byte();
         10:      return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         doc_bytes.push_back(s[i]);
   endtask

   // one token's worth of bytes, mostly well formed with random content
   task automatic append_token();
      logic [7:0] b;
      logic [7:0] quote;
      case ($urandom_range(0, 6))
         0: begin
            // text run, any byte but the opening bracket
            repeat ($urandom_range(1, 6)) begin
               b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : markup_byte();
               doc_bytes.push_back((b == CH_LT) ? 8'h3B : b);
            end
         end
         1: begin
            // comment, closed by hyphens, optional white space, bracket
            push_text("<!--");
            repeat ($urandom_range(0, 6))
               doc_bytes.push_back(markup_byte());
            repeat ($urandom_range(2, 3))
               doc_bytes.push_back(CH_DASH);
            repeat ($urandom_range(0, 2))
               doc_bytes.push_back(space_byte());
            doc_bytes.push_back(CH_GT);
         end
         2: begin
            // declaration, sometimes a broken comment opener
            push_text("<!");
            if ($urandom_range(0, 3) == 0) begin
               doc_bytes.push_back(CH_DASH);
               doc_bytes.push_back(letter_byte());
            end else begin
               push_text("DOCTYPE ");
            end
            if ($urandom_range(0, 1)) begin
               quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
               doc_bytes.push_back(quote);
               repeat ($urandom_range(0, 4)) begin
                  b = markup_byte();
                  doc_bytes.push_back((b == quote) ? letter_byte() : b);
               end
               doc_bytes.push_back(quote);
            end
            doc_bytes.push_back(CH_GT);
         end
         3, 4: begin
            // start or end tag with quoted attributes that may hide a bracket
            doc_bytes.push_back(CH_LT);
            if ($urandom_range(0, 2) == 0)
               doc_bytes.push_back(CH_SLASH);
            repeat ($urandom_range(1, 4))
               doc_bytes.push_back(letter_byte());
            repeat ($urandom_range(0, 2)) begin
               doc_bytes.push_back(space_byte());
               doc_bytes.push_back(letter_byte());
               doc_bytes.push_back(8'h3D);
               quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
               doc_bytes.push_back(quote);
               repeat ($urandom_range(0, 4)) begin
                  b = markup_byte();
                  doc_bytes.push_back((b == quote) ? letter_byte() : b);
               end
               doc_bytes.push_back(quote);
            end
            doc_bytes.push_back(CH_GT);
         end
         default: begin
            // noise
            repeat ($urandom_range(1, 8))
               doc_bytes.push_back($urandom_range(0, 1) ? markup_byte()
                                                         : 8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // one byte request; valid stays up across back-to-back requests
   task automatic send_request(input logic [7:0] b, input logic last);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, end_of_file: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_document();
      for (int i = 0; i < doc_bytes.size(); i++)
         send_request(doc_bytes[i], i == doc_bytes.size() - 1);
      doc_bytes.delete();
   endtask

   // result side: random stalls, one long hold-off to back up the block
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && requests_taken >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // request side and verdict
   initial begin
      int random_bytes;
      random_bytes = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // text closed by a bracket, then a lone bracket cut by end of file;
      // also the lowest and highest byte values
      doc_bytes = {8'h00, 8'hFF, CH_LT};
      send_document();
      // bang opener cut by end of file
      push_text("<!");
      send_document();
      // bang and one hyphen cut by end of file
      push_text("<!-");
      send_document();
      // bang, hyphen and another byte: a declaration
      push_text("<!-x>");
      send_document();
      // comment: high byte is not white space, then hyphen, vertical tab, bracket
      push_text("<!---");
      doc_bytes.push_back(8'hA0);
      doc_bytes.push_back(CH_DASH);
      doc_bytes.push_back(8'h0B);
      doc_bytes.push_back(CH_GT);
      send_document();
      // end tag with a quoted bracket, cut by end of file
      push_text("</'>'");
      send_document();

      // random documents, each ended by end of file, some cut short
      while (random_bytes < RANDOM_BYTES) begin
         repeat ($urandom_range(1, 6)) append_token();
         if ($urandom_range(0, 4) == 0)
            doc_bytes = doc_bytes[0:$urandom_range(0, doc_bytes.size() - 1)];
         random_bytes += doc_bytes.size();
         if (random_bytes >= QUIET_AFTER)
            quiet_phase = 1'b1;
         send_document();
      end
      req_valid <= 1'b0;

      // wait for every expected token, then a little longer for strays
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
